### sv/sbsi_pkg.sv
// Package of the separable bilinear sub-pixel interpolator.
// Holds the register index codes, field widths and the pipeline stage record.
// Depends on nothing; imported by the top level.
`default_nettype none

package sbsi_pkg;

	localparam int PIX_W    = 8;
	localparam int SMP_W    = 10;
	localparam int CFG_IW   = 8;
	localparam int CFG_DW   = 8;
	localparam int DIM_W    = 10;
	localparam int PHASE_W  = 4;

	typedef enum logic [CFG_IW-1:0] {
		REG_FILTER_MODE  = 8'd0,
		REG_PHASE_PAIR   = 8'd1,
		REG_BLOCK_WIDTH  = 8'd2,
		REG_BLOCK_HEIGHT = 8'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_COPY = 2'd0,
		MODE_HOR  = 2'd1,
		MODE_VER  = 2'd2,
		MODE_BOTH = 2'd3
	} filter_mode_t;

	// Everything an item carries from the read stage to the filter stage.
	typedef struct packed {
		logic               emit;
		logic               filt;
		logic               both;
		logic               last;
		logic               wr;
		logic [SMP_W-1:0]   wdata;
		logic [SMP_W-1:0]   direct;
		logic [SMP_W-1:0]   b;
		logic [PHASE_W-1:0] fv;
		logic               fwd;
		logic [SMP_W-1:0]   fwd_data;
	} stage_t;

endpackage

`default_nettype wire

### sv/sbsi_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is enabled.
// No dependencies.
`default_nettype none

module sbsi_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

### sv/separable_bilinear_subpel_interp.sv
// Top level of the separable 16-phase bilinear sub-pixel interpolator.
// Depends on sbsi_pkg and sbsi_ram (the line store).
//
// The block takes one pixel per clock while in_stall is low and gives at most one sample
// per clock. The first stage computes the horizontal tap and reads the line store; the
// second stage applies the vertical tap and writes the line store back, with the value
// being written forwarded to a read of the same column in the same cycle. The line store
// needs no clearing after reset, because each block fills its columns in its first row
// before it reads them. Any register write restarts the block at its first pixel.
`default_nettype none

module separable_bilinear_subpel_interp
	import sbsi_pkg::*;
#(
	parameter int MAX_LINE = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [PIX_W-1:0]  pixel,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [SMP_W-1:0]       sample,
	output logic                   last_sample,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CFG_IW-1:0] cfg_index,
	input  wire logic [CFG_DW-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_LINE);

	logic [1:0]        filter_mode_q;
	logic [7:0]        phase_pair_q;
	logic [7:0]        block_width_q;
	logic [7:0]        block_height_q;
	logic [PIX_W-1:0]  prev_pixel_q;
	logic [7:0]        col_q;
	logic [7:0]        row_q;

	logic              valid_s1;
	stage_t            st_s1;
	logic [AW-1:0]     addr_s1;
	logic              valid_s2;
	logic [SMP_W-1:0]  sample_s2;
	logic              last_s2;

	logic              move;
	logic              accept;
	logic              cfg_hit;
	logic              hor;
	logic              ver;
	logic [DIM_W-1:0]  w_eff;
	logic [DIM_W-1:0]  h_eff;
	logic [DIM_W-1:0]  win_w;
	logic [DIM_W-1:0]  win_h;
	logic [DIM_W-1:0]  col;
	logic [DIM_W-1:0]  row;
	logic [DIM_W-1:0]  col_p1;
	logic [DIM_W-1:0]  row_p1;
	logic [DIM_W-1:0]  col_nx;
	logic [DIM_W-1:0]  row_nx;
	logic [PHASE_W-1:0] fh;
	logic [4:0]        ch0;
	logic [12:0]       h_acc;
	logic [SMP_W-1:0]  hv;
	logic [AW-1:0]     addr_s0;
	stage_t            st_s0;

	logic [SMP_W-1:0]  rd_data;
	logic [SMP_W-1:0]  m_s1;
	logic [4:0]        cv0_s1;
	logic [14:0]       v_acc;
	logic [SMP_W-1:0]  filt_val;

	assign move      = !valid_s2 || !out_stall;
	assign in_stall  = !move;
	assign accept    = in_valid && move;
	assign cfg_ready = 1'b1;
	assign out_valid   = valid_s2;
	assign sample      = sample_s2;
	assign last_sample = last_s2;

	always_comb begin
		cfg_hit = 1'b0;
		case (reg_idx_t'(cfg_index))
			REG_FILTER_MODE, REG_PHASE_PAIR, REG_BLOCK_WIDTH, REG_BLOCK_HEIGHT: cfg_hit = cfg_valid;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_mode_q  <= MODE_BOTH;
			phase_pair_q   <= 8'd0;
			block_width_q  <= 8'd8;
			block_height_q <= 8'd8;
		end else if (cfg_valid) begin
			case (reg_idx_t'(cfg_index))
				REG_FILTER_MODE:  filter_mode_q  <= cfg_data[1:0];
				REG_PHASE_PAIR:   phase_pair_q   <= cfg_data;
				REG_BLOCK_WIDTH:  block_width_q  <= cfg_data;
				REG_BLOCK_HEIGHT: block_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Window geometry, position of the incoming pixel, horizontal tap and stage record.
	always_comb begin
		hor = filter_mode_q[0];
		ver = filter_mode_q[1];
		if (block_width_q == 8'd0) begin
			w_eff = DIM_W'(1);
		end else if ({2'b00, block_width_q} > DIM_W'(MAX_LINE)) begin
			w_eff = DIM_W'(MAX_LINE);
		end else begin
			w_eff = {2'b00, block_width_q};
		end
		h_eff = (block_height_q == 8'd0) ? DIM_W'(1) : {2'b00, block_height_q};
		win_w = w_eff + {{(DIM_W-1){1'b0}}, hor};
		win_h = h_eff + {{(DIM_W-1){1'b0}}, ver};
		col = ({2'b00, col_q} >= win_w) ? '0 : {2'b00, col_q};
		row = ({2'b00, row_q} >= win_h) ? '0 : {2'b00, row_q};
		col_p1 = col + DIM_W'(1);
		row_p1 = row + DIM_W'(1);
		if (col_p1 >= win_w) begin
			col_nx = '0;
			row_nx = (row_p1 >= win_h) ? '0 : row_p1;
		end else begin
			col_nx = col_p1;
			row_nx = row;
		end

		fh    = phase_pair_q[3:0];
		ch0   = 5'd16 - {1'b0, fh};
		h_acc = {8'b0, ch0} * {5'b0, prev_pixel_q} + {9'b0, fh} * {5'b0, pixel} + 13'd2;
		hv    = h_acc[11:2];

		addr_s0 = hor ? AW'(col - DIM_W'(1)) : AW'(col);

		st_s0.last     = (col_p1 >= win_w) && (row_p1 >= win_h);
		st_s0.both     = hor;
		st_s0.fv       = phase_pair_q[7:4];
		st_s0.direct   = hv;
		st_s0.b        = hor ? hv : {2'b00, pixel};
		st_s0.wdata    = hor ? hv : {2'b00, pixel};
		st_s0.fwd      = valid_s1 && st_s1.wr && (addr_s1 == addr_s0);
		st_s0.fwd_data = st_s1.wdata;
		case (filter_mode_t'(filter_mode_q))
			MODE_COPY: begin
				st_s0.emit   = 1'b1;
				st_s0.filt   = 1'b0;
				st_s0.wr     = 1'b0;
				st_s0.direct = {pixel, 2'b00};
			end
			MODE_HOR: begin
				st_s0.emit = (col != '0);
				st_s0.filt = 1'b0;
				st_s0.wr   = 1'b0;
			end
			MODE_VER: begin
				st_s0.emit = (row != '0);
				st_s0.filt = 1'b1;
				st_s0.wr   = 1'b1;
			end
			default: begin
				st_s0.emit = (col != '0) && (row != '0);
				st_s0.filt = 1'b1;
				st_s0.wr   = (col != '0);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pixel_q <= '0;
			col_q        <= '0;
			row_q        <= '0;
		end else if (cfg_hit) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			prev_pixel_q <= pixel;
			col_q        <= col_nx[7:0];
			row_q        <= row_nx[7:0];
		end
	end

	sbsi_ram #(
		.WIDTH(SMP_W),
		.DEPTH(MAX_LINE)
	) u_line_store (
		.clk     (clk),
		.wr_en   (valid_s1 && st_s1.wr && move),
		.wr_addr (addr_s1),
		.wr_data (st_s1.wdata),
		.rd_en   (accept),
		.rd_addr (addr_s0),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (move) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			st_s1   <= st_s0;
			addr_s1 <= addr_s0;
		end
	end

	// Vertical tap on the stored line value.
	always_comb begin
		m_s1     = st_s1.fwd ? st_s1.fwd_data : rd_data;
		cv0_s1   = 5'd16 - {1'b0, st_s1.fv};
		v_acc    = {10'b0, cv0_s1} * {5'b0, m_s1} + {11'b0, st_s1.fv} * {5'b0, st_s1.b}
			+ (st_s1.both ? 15'd8 : 15'd2);
		filt_val = st_s1.both ? v_acc[13:4] : v_acc[11:2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move) begin
			valid_s2 <= valid_s1 && st_s1.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			sample_s2 <= st_s1.filt ? filt_val : st_s1.direct;
			last_s2   <= st_s1.last;
		end
	end

endmodule

`default_nettype wire
